/* rtl/core/vgs_pkg.sv */
// vgs_pkg: shared types and sizing constants for the vertex gap snapper
// no dependencies; imported by vgs_cell, vgs_pair_unit and vertex_gap_snapper
`timescale 1ns / 1ps
`default_nettype none

package vgs_pkg;

    // capacity of the vertex chain, one cell per vertex
    localparam int MAX_VERTICES = 64;
    localparam int HEAD_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int TOL_W        = 32;
    localparam int IDX_W        = 6;

    // input word: one vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      last_vertex;
    } t_in_word;

    // result word: one snapped vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [IDX_W-1:0]          vertex_index;
        logic                      any_snapped;
        logic                      overflow;
        logic                      last_result;
    } t_out_word;

    // stored position, raw two's complement bits
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_vertex;

    // pair unit status toward the sequencer
    typedef struct packed {
        logic done;
        logic snap;
    } t_pair_stat;

endpackage

`default_nettype wire

/* rtl/core/vgs_cell.sv */
// vgs_cell: one storage cell of the vertex chain, loads its neighbor on shift
// depends on vgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vgs_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire vgs_pkg::t_vertex i_vtx,
    output vgs_pkg::t_vertex     o_vtx
);
    import vgs_pkg::*;

    t_vertex r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_vtx <= i_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

`default_nettype wire

/* rtl/core/vgs_pair_unit.sv */
// vgs_pair_unit: four-stage distance test and midpoint for one vertex pair
// depends on vgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module vgs_pair_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [vgs_pkg::TOL_W-1:0] i_tol,
    input  wire vgs_pkg::t_vertex   i_pivot,
    input  wire vgs_pkg::t_vertex   i_cand,
    output vgs_pkg::t_pair_stat     o_stat,
    output vgs_pkg::t_vertex        o_mid
);
    import vgs_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int SQ_W = 2 * TOL_W;

    function automatic logic [DW-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic [DW-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        abs_diff = d[DW-1] ? (~d + DW'(1)) : d;
    endfunction

    // floor of the exact sum over two
    function automatic logic [COORD_W-1:0] mid_of(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
        logic [DW-1:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        mid_of = s[DW-1:1];
    endfunction

    logic [DW-1:0]   w_ax, w_ay, w_az;
    logic [SQ_W-1:0] r_tol_sq;

    // stage 1
    logic            r_v1, r_far1;
    logic [DW-1:0]   r_ax, r_ay, r_az;
    t_vertex         r_mid;
    // stage 2
    logic            r_v2, r_far2;
    logic [SQ_W-1:0] r_sx, r_sy, r_sz;
    // stage 3
    logic            r_v3, r_far3;
    logic [SQ_W:0]   r_sxy;
    logic [SQ_W-1:0] r_sz3;
    // stage 4
    logic            r_v4, r_snap;
    logic [SQ_W+1:0] n_sum;

    assign w_ax = abs_diff(i_pivot.x, i_cand.x);
    assign w_ay = abs_diff(i_pivot.y, i_cand.y);
    assign w_az = abs_diff(i_pivot.z, i_cand.z);

    assign n_sum = (SQ_W+2)'(r_sxy) + (SQ_W+2)'(r_sz3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol_sq <= SQ_W'(i_tol) * SQ_W'(i_tol);
        if (i_go) begin
            r_ax   <= w_ax;
            r_ay   <= w_ay;
            r_az   <= w_az;
            // any axis beyond the tolerance fails before squaring
            r_far1 <= (w_ax > DW'(i_tol)) || (w_ay > DW'(i_tol)) || (w_az > DW'(i_tol));
            r_mid.x <= mid_of(i_pivot.x, i_cand.x);
            r_mid.y <= mid_of(i_pivot.y, i_cand.y);
            r_mid.z <= mid_of(i_pivot.z, i_cand.z);
        end
        r_far2 <= r_far1;
        r_sx   <= SQ_W'(r_ax[TOL_W-1:0]) * SQ_W'(r_ax[TOL_W-1:0]);
        r_sy   <= SQ_W'(r_ay[TOL_W-1:0]) * SQ_W'(r_ay[TOL_W-1:0]);
        r_sz   <= SQ_W'(r_az[TOL_W-1:0]) * SQ_W'(r_az[TOL_W-1:0]);
        r_far3 <= r_far2;
        r_sxy  <= (SQ_W+1)'(r_sx) + (SQ_W+1)'(r_sy);
        r_sz3  <= r_sz;
        // coincident pairs never move
        r_snap <= !r_far3 && (n_sum != '0) && (n_sum <= (SQ_W+2)'(r_tol_sq));
    end

    assign o_stat.done = r_v4;
    assign o_stat.snap = r_snap;
    assign o_mid       = r_mid;

endmodule

`default_nettype wire

/* rtl/core/vertex_gap_snapper.sv */
// vertex_gap_snapper: top level, vertex chain, pass sequencer and result register
// depends on vgs_pkg, vgs_cell, vgs_pair_unit
`timescale 1ns / 1ps
`default_nettype none

// Vertices are taken one word per cycle while busy is low (start high). The
// word marked last_vertex starts the snap pass; busy then stays high until the
// last result word is registered, so that word shows on the result ports in
// the first cycle with busy low. Vertices past MAX_VERTICES are dropped and
// the overflow flag is set on every result of that set. Results come out in
// load order, one per cycle on o_res_strobe, with no gaps; the receiver cannot
// stall, so it must take every strobed word. Steps for a set of n vertices,
// D = MAX_VERTICES: the vertices load into the chain, then the chain of D
// cells rotates until vertex 0 sits in cell 0, the pass turns the chain once
// around and one cell further for each of the n pivots, pausing on each of
// the n*(n-1)/2 pairs for the four-stage distance unit, and emission turns
// the chain once more, each word going out through the result register.
// Configuration writes to the tolerance are taken at any time but must only
// be made while busy is low.

module vertex_gap_snapper (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire vgs_pkg::t_in_word    i_vertex,
    output logic                      busy,
    input  wire logic                 i_cfg_we,
    input  wire logic [vgs_pkg::TOL_W-1:0] i_cfg_data,
    output logic                      o_res_strobe,
    output vgs_pkg::t_out_word        o_result
);
    import vgs_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SEEK,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [TOL_W-1:0]  r_tol;
    logic [CNT_W-1:0]  r_count;      // vertices held in this set
    logic              r_drop;
    logic [HEAD_W-1:0] r_head;       // load index of the vertex in cell 0
    logic [HEAD_W-1:0] r_piv;        // current pivot index
    logic [CNT_W-1:0]  r_step;       // rotation step within a sweep or emission
    t_vertex           r_pivot;
    logic              r_snapped;
    logic              r_pair_busy;
    logic              r_res_strobe;
    t_out_word         r_result;

    // chain wiring: cell k takes from cell k+1, the last cell from the tail mux
    t_vertex           w_cell [MAX_VERTICES];
    t_vertex           w_next [MAX_VERTICES];
    t_vertex           w_tail;
    t_vertex           w_load_vtx;
    t_vertex           w_head_vtx;
    t_vertex           w_mid;
    t_pair_stat        w_stat;
    logic              w_shift;
    logic              w_go;
    logic              w_accept;
    logic              w_room;
    logic              w_pair_ok;
    logic              w_pair_done;
    logic              w_step_end;
    logic              w_last_pivot;
    logic              w_head_live;
    logic              w_emit_end;
    logic [HEAD_W-1:0] w_head_inc;

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_chain
            if (g == MAX_VERTICES - 1) begin : g_tail
                assign w_next[g] = w_tail;
            end else begin : g_body
                assign w_next[g] = w_cell[g+1];
            end
            vgs_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_vtx   (w_next[g]),
                .o_vtx   (w_cell[g])
            );
        end
    endgenerate

    vgs_pair_unit u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_tol   (r_tol),
        .i_pivot (r_pivot),
        .i_cand  (w_head_vtx),
        .o_stat  (w_stat),
        .o_mid   (w_mid)
    );

    assign busy       = (r_state != S_LOAD);
    assign w_accept   = start && !busy;
    assign w_room     = (r_count < CNT_W'(MAX_VERTICES));
    assign w_head_vtx = w_cell[0];

    assign w_load_vtx.x = i_vertex.coord_x;
    assign w_load_vtx.y = i_vertex.coord_y;
    assign w_load_vtx.z = i_vertex.coord_z;

    assign w_head_inc   = (r_head == HEAD_W'(MAX_VERTICES - 1)) ? '0 : r_head + HEAD_W'(1);
    // pair (pivot, pivot + step) exists only inside the set
    assign w_pair_ok    = ((CNT_W+1)'(r_piv) + (CNT_W+1)'(r_step)) < (CNT_W+1)'(r_count);
    assign w_pair_done  = r_pair_busy && w_stat.done;
    assign w_step_end   = (r_step == CNT_W'(MAX_VERTICES));
    assign w_last_pivot = (CNT_W'(r_piv) == r_count - CNT_W'(1));
    assign w_head_live  = (CNT_W'(r_head) < r_count);
    assign w_emit_end   = (r_state == S_EMIT) && (r_step == CNT_W'(MAX_VERTICES - 1));

    // rotation control and tail source
    always_comb begin
        w_shift = 1'b0;
        w_go    = 1'b0;
        w_tail  = w_head_vtx;
        case (r_state)
            S_LOAD: begin
                if (w_accept && w_room) begin
                    w_shift = 1'b1;
                    w_tail  = w_load_vtx;
                end
            end
            S_SEEK: begin
                // rotate until vertex 0 sits in cell 0
                w_shift = (r_head != '0);
            end
            S_SWEEP: begin
                if (r_step == '0) begin
                    w_shift = 1'b1;
                end else if (w_step_end) begin
                    // pivot goes back into its own slot
                    w_shift = 1'b1;
                    w_tail  = r_pivot;
                end else if (!w_pair_ok) begin
                    w_shift = 1'b1;
                end else if (w_pair_done) begin
                    w_shift = 1'b1;
                    w_tail  = w_stat.snap ? w_mid : w_head_vtx;
                end else if (!r_pair_busy) begin
                    w_go = 1'b1;
                end
            end
            S_EMIT: begin
                w_shift = 1'b1;
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_tol        <= '0;
            r_count      <= '0;
            r_drop       <= 1'b0;
            r_head       <= '0;
            r_piv        <= '0;
            r_step       <= '0;
            r_snapped    <= 1'b0;
            r_pair_busy  <= 1'b0;
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= (r_state == S_EMIT) && w_head_live;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (w_emit_end) begin
                // new set: cell positions are relative, so the head restarts at 0
                r_head <= '0;
            end else if (w_shift) begin
                r_head <= w_head_inc;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_vertex.last_vertex) begin
                            r_snapped <= 1'b0;
                            r_state   <= S_SEEK;
                        end
                    end
                end
                S_SEEK: begin
                    if (r_head == '0) begin
                        r_state <= S_SWEEP;
                        r_step  <= '0;
                        r_piv   <= '0;
                    end
                end
                S_SWEEP: begin
                    if (r_step == '0) begin
                        r_pivot <= w_head_vtx;
                        r_step  <= CNT_W'(1);
                    end else if (w_step_end) begin
                        r_step <= '0;
                        if (w_last_pivot) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_piv <= r_piv + HEAD_W'(1);
                        end
                    end else if (!w_pair_ok) begin
                        r_step <= r_step + CNT_W'(1);
                    end else if (w_pair_done) begin
                        r_step      <= r_step + CNT_W'(1);
                        r_pair_busy <= 1'b0;
                        if (w_stat.snap) begin
                            r_pivot   <= w_mid;
                            r_snapped <= 1'b1;
                        end
                    end else if (!r_pair_busy) begin
                        r_pair_busy <= 1'b1;
                    end
                end
                S_EMIT: begin
                    // one full turn; vertices of the set leave cell 0 in load order
                    r_result.out_x        <= w_head_vtx.x;
                    r_result.out_y        <= w_head_vtx.y;
                    r_result.out_z        <= w_head_vtx.z;
                    r_result.vertex_index <= IDX_W'(r_head);
                    r_result.any_snapped  <= r_snapped;
                    r_result.overflow     <= r_drop;
                    r_result.last_result  <= (CNT_W'(r_head) == r_count - CNT_W'(1));
                    if (w_emit_end) begin
                        r_state <= S_LOAD;
                        r_step  <= '0;
                        r_count <= '0;
                        r_drop  <= 1'b0;
                    end else begin
                        r_step <= r_step + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_result     = r_result;

endmodule

`default_nettype wire
